// ===== design/nca_pkg.sv =====
// Shared types and constants for the nearest-centroid track association block.
package nca_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_DEPTH = 1'b1;

    // Register widths and reset values.
    localparam int RADIUS_W = 12;
    localparam int DEPTH_W  = 3;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd80;
    localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = 3'd5;

    // Width of the frames_back result field.
    localparam int BACK_W = 3;

    // Input action codes.
    localparam logic ACT_OBJECT = 1'b0;
    localparam logic ACT_CLOSE  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_FRAME,
        ST_SCAN,
        ST_DECIDE,
        ST_STORE
    } state_t;

endpackage

// ===== design/nearest_centroid_track_assoc.sv =====
// Top level of the nearest-centroid track association block.
//
//   Channel   Signals                                   Direction
//   config    cfg_write, cfg_index, cfg_data            write only, no wait
//   input     in_valid/in_ready: action, center_x/y     one beat per object or close
//   output    out_valid/out_ready: track_id, new_track, one beat per object
//             frames_back
//
// A close beat is absorbed in the idle state. An object beat runs setup, then a frame
// step per frame back and, for each non-empty frame, a scan and a decide step, paced by
// the single distance unit that scans one stored entry per cycle, and ends in store.
// in_ready is high only while the sequencer is idle. A finished result waits in the
// output register; a following result stalls in the store step until it is taken.
// Reset clears counts, slot pointers and the id counter; the entry memory needs none.
module nearest_centroid_track_assoc #(
    parameter int MAX_OBJECTS    = 64,
    parameter int HISTORY_FRAMES = 5,
    parameter int COORD_BITS     = 12,
    parameter int TRACK_ID_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [nca_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nca_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [COORD_BITS-1:0]          center_x,
    input  logic [COORD_BITS-1:0]          center_y,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [TRACK_ID_BITS-1:0]       track_id,
    output logic                           new_track,
    output logic [nca_pkg::BACK_W-1:0]     frames_back
);

    import nca_pkg::*;

    localparam int SLOTS     = HISTORY_FRAMES + 1;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int IDX_W     = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W     = $clog2(MAX_OBJECTS + 1);
    localparam int AGE_RAW_W = $clog2(SLOTS + 1);
    localparam int AGE_W     = (AGE_RAW_W > DEPTH_W) ? AGE_RAW_W : DEPTH_W;
    localparam int ENT_W     = 2 * COORD_BITS + TRACK_ID_BITS + 1;
    localparam int TAG_W     = ENT_W + IDX_W + 1;
    localparam int DIST_W    = 2 * COORD_BITS + 1;
    localparam int R2_W      = 2 * RADIUS_W;
    localparam int CMP_W     = (DIST_W > R2_W) ? DIST_W : R2_W;
    localparam int ADDR_W    = SLOT_W + IDX_W;
    localparam int MEM_DEPTH = SLOTS * (1 << IDX_W);

    localparam logic [AGE_W-1:0]  HIST_C    = AGE_W'(HISTORY_FRAMES);
    localparam logic [AGE_W-1:0]  SLOTS_C   = AGE_W'(SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  MAX_C     = CNT_W'(MAX_OBJECTS);

    state_t state_reg, state_next;

    // Configuration registers.
    logic [RADIUS_W-1:0] radius_reg;
    logic [DEPTH_W-1:0]  depth_cfg_reg;

    // Frame bookkeeping.
    logic [SLOT_W-1:0]        cur_slot_reg, cur_slot_next;
    logic [AGE_W-1:0]         frames_held_reg, frames_held_next;
    logic [CNT_W-1:0]         cur_count_reg, cur_count_next;
    logic [CNT_W-1:0]         counts_reg [SLOTS];
    logic [TRACK_ID_BITS-1:0] last_id_reg, last_id_next;
    logic                     close_go;

    // Per-object search state.
    logic [COORD_BITS-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [R2_W-1:0]       r2_reg, r2_next;
    logic [AGE_W-1:0]      depth_reg, depth_next, age_reg, age_next, back_reg, back_next;
    logic [SLOT_W-1:0]     scan_slot_reg, scan_slot_next;
    logic [CNT_W-1:0]      n_reg, n_next;
    logic                  issue_on_reg, issue_on_next;
    logic [IDX_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                  first_reg, first_next, found_reg, found_next;
    logic [DIST_W-1:0]     best_d_reg, best_d_next;
    logic [ENT_W-1:0]      best_ent_reg, best_ent_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;

    // Result register.
    logic                     out_valid_reg, out_valid_next;
    logic [TRACK_ID_BITS-1:0] track_id_reg, track_id_next;
    logic                     new_track_reg, new_track_next;
    logic [BACK_W-1:0]        frames_back_reg, frames_back_next;

    // Entry memory and its read side.
    logic [ENT_W-1:0]  mem [MEM_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa, mem_ra;
    logic [ENT_W-1:0]  mem_wd;
    logic [ENT_W-1:0]  rd_q_reg;
    logic              rd_v_reg, rd_last_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              issue, issue_last;

    // Distance unit outputs.
    logic              dv;
    logic [DIST_W-1:0] sq_dist;
    logic [TAG_W-1:0]  dtag;
    logic              d_last;
    logic [IDX_W-1:0]  d_idx;
    logic [ENT_W-1:0]  d_ent;

    // Helpers for the frame and id steps.
    logic [AGE_W-1:0]         cur_ext, frame_slot_w, sd_c;
    logic [SLOT_W-1:0]        frame_slot;
    logic [CNT_W-1:0]         slot_count;
    logic [TRACK_ID_BITS-1:0] id_inc;
    logic                     match_ok;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= RADIUS_RESET;
            depth_cfg_reg <= DEPTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MATCH_RADIUS: radius_reg    <= cfg_data[RADIUS_W-1:0];
                REG_SEARCH_DEPTH: depth_cfg_reg <= cfg_data[DEPTH_W-1:0];
                default:          radius_reg    <= radius_reg;
            endcase
        end
    end

    // Slot of the frame that lies age_reg frames back.
    assign cur_ext      = AGE_W'(cur_slot_reg);
    assign frame_slot_w = (cur_ext >= age_reg) ? (cur_ext - age_reg)
                                               : (cur_ext + SLOTS_C - age_reg);
    assign frame_slot   = frame_slot_w[SLOT_W-1:0];
    assign slot_count   = counts_reg[frame_slot];

    // Effective search depth: a zero setting counts as one, then capped at the history and the frames held.
    always_comb
    begin
        sd_c = AGE_W'(depth_cfg_reg);
        if (sd_c == '0)
        begin
            sd_c = AGE_W'(1);
        end
        if (sd_c > HIST_C)
        begin
            sd_c = HIST_C;
        end
        if (sd_c > frames_held_reg)
        begin
            sd_c = frames_held_reg;
        end
    end

    // Next track id, skipping zero on wrap.
    always_comb
    begin
        id_inc = last_id_reg + 1'b1;
        if (id_inc == '0)
        begin
            id_inc = TRACK_ID_BITS'(1);
        end
    end

    assign issue_last = ({{(CNT_W - IDX_W){1'b0}}, issue_idx_reg} == (n_reg - 1'b1));
    assign mem_ra     = {scan_slot_reg, issue_idx_reg};
    assign match_ok   = (CMP_W'(best_d_reg) < CMP_W'(r2_reg)) && !best_ent_reg[0];

    // Sequencer: next state, strobes and register updates.
    always_comb
    begin
        state_next       = state_reg;
        cur_slot_next    = cur_slot_reg;
        frames_held_next = frames_held_reg;
        cur_count_next   = cur_count_reg;
        last_id_next     = last_id_reg;
        qx_next          = qx_reg;
        qy_next          = qy_reg;
        r2_next          = r2_reg;
        depth_next       = depth_reg;
        age_next         = age_reg;
        back_next        = back_reg;
        scan_slot_next   = scan_slot_reg;
        n_next           = n_reg;
        issue_on_next    = issue_on_reg;
        issue_idx_next   = issue_idx_reg;
        first_next       = first_reg;
        found_next       = found_reg;
        best_d_next      = best_d_reg;
        best_ent_next    = best_ent_reg;
        best_idx_next    = best_idx_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        track_id_next    = track_id_reg;
        new_track_next   = new_track_reg;
        frames_back_next = frames_back_reg;
        in_ready         = 1'b0;
        close_go         = 1'b0;
        issue            = 1'b0;
        mem_we           = 1'b0;
        mem_wa           = '0;
        mem_wd           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == ACT_CLOSE)
                    begin
                        close_go       = 1'b1;
                        cur_slot_next  = (cur_slot_reg == SLOT_LAST) ? '0
                                                                     : cur_slot_reg + 1'b1;
                        cur_count_next = '0;
                        if (frames_held_reg < HIST_C)
                        begin
                            frames_held_next = frames_held_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        qx_next    = center_x;
                        qy_next    = center_y;
                        state_next = ST_SETUP;
                    end
                end
            end

            ST_SETUP:
            begin
                r2_next    = R2_W'(radius_reg) * R2_W'(radius_reg);
                depth_next = sd_c;
                age_next   = AGE_W'(1);
                found_next = 1'b0;
                state_next = ST_FRAME;
            end

            ST_FRAME:
            begin
                if (age_reg > depth_reg)
                begin
                    state_next = ST_STORE;
                end
                else if (slot_count == '0)
                begin
                    age_next = age_reg + 1'b1;
                end
                else
                begin
                    scan_slot_next = frame_slot;
                    n_next         = slot_count;
                    issue_on_next  = 1'b1;
                    issue_idx_next = '0;
                    first_next     = 1'b1;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Issue one entry read per cycle.
                if (issue_on_reg)
                begin
                    issue = 1'b1;
                    if (issue_last)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end
                // Keep the first nearest entry as distances come back.
                if (dv)
                begin
                    if (first_reg || (sq_dist < best_d_reg))
                    begin
                        best_d_next   = sq_dist;
                        best_ent_next = d_ent;
                        best_idx_next = d_idx;
                    end
                    first_next = 1'b0;
                    if (d_last)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (match_ok)
                begin
                    mem_we     = 1'b1;
                    mem_wa     = {scan_slot_reg, best_idx_reg};
                    mem_wd     = {best_ent_reg[ENT_W-1:1], 1'b1};
                    found_next = 1'b1;
                    back_next  = age_reg;
                    state_next = ST_STORE;
                end
                else
                begin
                    age_next   = age_reg + 1'b1;
                    state_next = ST_FRAME;
                end
            end

            ST_STORE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (found_reg)
                    begin
                        track_id_next    = best_ent_reg[TRACK_ID_BITS:1];
                        new_track_next   = 1'b0;
                        frames_back_next = back_reg[BACK_W-1:0];
                    end
                    else
                    begin
                        last_id_next     = id_inc;
                        track_id_next    = id_inc;
                        new_track_next   = 1'b1;
                        frames_back_next = '0;
                    end
                    // Objects beyond the frame capacity are reported but not kept.
                    if (cur_count_reg < MAX_C)
                    begin
                        mem_we         = 1'b1;
                        mem_wa         = {cur_slot_reg, cur_count_reg[IDX_W-1:0]};
                        mem_wd         = {qx_reg, qy_reg, track_id_next, 1'b0};
                        cur_count_next = cur_count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cur_slot_reg    <= '0;
            frames_held_reg <= '0;
            cur_count_reg   <= '0;
            last_id_reg     <= '0;
            issue_on_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            rd_v_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_slot_reg    <= cur_slot_next;
            frames_held_reg <= frames_held_next;
            cur_count_reg   <= cur_count_next;
            last_id_reg     <= last_id_next;
            issue_on_reg    <= issue_on_next;
            out_valid_reg   <= out_valid_next;
            rd_v_reg        <= issue;
        end
    end

    // Per-slot object counts, written when a frame closes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                counts_reg[s] <= '0;
            end
        end
        else if (close_go)
        begin
            counts_reg[cur_slot_reg] <= cur_count_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        qx_reg          <= qx_next;
        qy_reg          <= qy_next;
        r2_reg          <= r2_next;
        depth_reg       <= depth_next;
        age_reg         <= age_next;
        back_reg        <= back_next;
        scan_slot_reg   <= scan_slot_next;
        n_reg           <= n_next;
        issue_idx_reg   <= issue_idx_next;
        first_reg       <= first_next;
        found_reg       <= found_next;
        best_d_reg      <= best_d_next;
        best_ent_reg    <= best_ent_next;
        best_idx_reg    <= best_idx_next;
        track_id_reg    <= track_id_next;
        new_track_reg   <= new_track_next;
        frames_back_reg <= frames_back_next;
        rd_last_reg     <= issue_last;
        rd_idx_reg      <= issue_idx_reg;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_q_reg <= mem[mem_ra];
    end

    // Shared distance unit.
    nca_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .TAG_W      (TAG_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_v_reg),
        .qx        (qx_reg),
        .qy        (qy_reg),
        .ex        (rd_q_reg[ENT_W-1 -: COORD_BITS]),
        .ey        (rd_q_reg[ENT_W-COORD_BITS-1 -: COORD_BITS]),
        .in_tag    ({rd_last_reg, rd_idx_reg, rd_q_reg}),
        .out_valid (dv),
        .sq_dist   (sq_dist),
        .out_tag   (dtag)
    );

    assign d_last = dtag[TAG_W-1];
    assign d_idx  = dtag[TAG_W-2 -: IDX_W];
    assign d_ent  = dtag[ENT_W-1:0];

    assign out_valid   = out_valid_reg;
    assign track_id    = track_id_reg;
    assign new_track   = new_track_reg;
    assign frames_back = frames_back_reg;

endmodule

// ===== design/nca_dist_unit.sv =====
// Pipelined squared-distance unit shared by every stored-entry comparison.
module nca_dist_unit #(
    parameter int COORD_BITS = 12,
    parameter int TAG_W      = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [COORD_BITS-1:0]     qx,
    input  logic [COORD_BITS-1:0]     qy,
    input  logic [COORD_BITS-1:0]     ex,
    input  logic [COORD_BITS-1:0]     ey,
    input  logic [TAG_W-1:0]          in_tag,
    output logic                      out_valid,
    output logic [2*COORD_BITS:0]     sq_dist,
    output logic [TAG_W-1:0]          out_tag
);

    localparam int SQ_W = 2 * COORD_BITS;

    logic                  v1_reg, v2_reg, v3_reg;
    logic [COORD_BITS-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]       sqx_reg, sqy_reg;
    logic [SQ_W:0]         sum_reg;
    logic [TAG_W-1:0]      tag1_reg, tag2_reg, tag3_reg;

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage one takes absolute differences, stage two squares them, stage three sums.
    always_ff @(posedge clk)
    begin
        dx_reg   <= (ex >= qx) ? (ex - qx) : (qx - ex);
        dy_reg   <= (ey >= qy) ? (ey - qy) : (qy - ey);
        tag1_reg <= in_tag;
        sqx_reg  <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg  <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        tag2_reg <= tag1_reg;
        sum_reg  <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
        tag3_reg <= tag2_reg;
    end

    assign out_valid = v3_reg;
    assign sq_dist   = sum_reg;
    assign out_tag   = tag3_reg;

endmodule

// ===== design/nca_checker.sv =====
// Port-level assertions for the track association block, with their bind.
module nca_checker #(
    parameter int TRACK_ID_BITS = 16
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       action,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [TRACK_ID_BITS-1:0]   track_id,
    input logic                       new_track,
    input logic [nca_pkg::BACK_W-1:0] frames_back
);

    import nca_pkg::*;

    // A fresh track never reports a matched frame age.
    a_new_no_age: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && new_track |-> frames_back == '0)
        else $error("new track with nonzero frames_back");

    // An inherited track always names the frame it came from.
    a_match_age: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !new_track |-> frames_back != '0)
        else $error("matched track with zero frames_back");

    // Track id zero is never issued.
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> track_id != '0)
        else $error("track id zero on output");

    // An accepted object beat keeps the block busy for at least the next cycle.
    a_busy_after_object: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ACT_OBJECT) |=> !in_ready)
        else $error("input ready right after an object beat");

    // A stalled result beat holds its track id and new-track flag.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(track_id) && $stable(new_track))
        else $error("stalled output beat changed");

endmodule

bind nearest_centroid_track_assoc nca_checker #(
    .TRACK_ID_BITS (TRACK_ID_BITS)
) u_nca_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .track_id    (track_id),
    .new_track   (new_track),
    .frames_back (frames_back)
);
